// ===== rtl/sps_pkg.sv =====
// shared constants, codes and control types of the sensor poll backoff scheduler
package sps_pkg;

   localparam int SLOTS = 4;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int IDX_W = 2;
   localparam int TIME_W = 32;
   localparam int DELAY_W = 20;
   localparam int TEMP_W = 11;
   localparam int HUM_W = 10;
   localparam int LIMIT_W = 10;
   localparam int COUNT_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENSOR_COUNT = 3'd0,
      CSR_POLL_PERIOD  = 3'd1,
      CSR_BACKOFF_MIN  = 3'd2,
      CSR_BACKOFF_MAX  = 3'd3,
      CSR_TEMP_LIMIT   = 3'd4,
      CSR_HUM_LIMIT    = 3'd5
   } csr_index_type;

   typedef enum logic {
      CMD_CHECK  = 1'b0,
      CMD_REPORT = 1'b1
   } command_type;

   localparam logic [COUNT_W-1:0] RST_SENSOR_COUNT = COUNT_W'(4);
   localparam logic [DELAY_W-1:0] RST_POLL_PERIOD = DELAY_W'(2000);
   localparam logic [DELAY_W-1:0] RST_BACKOFF_MIN = DELAY_W'(1000);
   localparam logic [DELAY_W-1:0] RST_BACKOFF_MAX = DELAY_W'(60000);
   localparam logic [LIMIT_W-1:0] RST_TEMP_LIMIT = LIMIT_W'(5);
   localparam logic [LIMIT_W-1:0] RST_HUM_LIMIT = LIMIT_W'(10);
   localparam logic [DELAY_W-1:0] RST_RETRY_DELAY = DELAY_W'(1000);

   typedef struct packed {
      logic load;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/sps_if.sv =====
// request and response channel interfaces of the sensor poll backoff scheduler
interface sps_req_if import sps_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [IDX_W-1:0]         sensor_index;
   logic [TIME_W-1:0]        now_ms;
   logic                     read_ok;
   logic signed [TEMP_W-1:0] temp_tenths;
   logic [HUM_W-1:0]         hum_tenths;

   modport source (output valid, command, sensor_index, now_ms, read_ok, temp_tenths,
                   hum_tenths, input ready);
   modport sink (input valid, command, sensor_index, now_ms, read_ok, temp_tenths,
                 hum_tenths, output ready);
endinterface

interface sps_rsp_if import sps_pkg::*;;
   logic                valid;
   logic                ready;
   logic                rejected;
   logic                due;
   logic                reading_valid;
   logic                changed_any;
   logic                changed_significant;
   logic [DELAY_W-1:0]  retry_delay_ms;
   logic [TIME_W-1:0]   next_deadline_ms;

   modport source (output valid, rejected, due, reading_valid, changed_any,
                   changed_significant, retry_delay_ms, next_deadline_ms, input ready);
   modport sink (input valid, rejected, due, reading_valid, changed_any,
                 changed_significant, retry_delay_ms, next_deadline_ms, output ready);
endinterface

// ===== rtl/sps_ctrl.sv =====
// controller: takes one request beat, then commits it once the response register is free
module sps_ctrl import sps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
                  ready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign cmd.load = req_valid && ready_ff;
   assign cmd.commit = (state_ff == ST_EXEC) && status.out_free;

`ifndef SYNTHESIS
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready && !cmd.load)
      else $error("request taken while a beat is still in progress");

   a_commit_reopens: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req_ready)
      else $error("request side not reopened after commit");
`endif

endmodule

// ===== rtl/sps_dp.sv =====
// datapath: input holding register, sensor table, backoff and change logic, response register
module sps_dp import sps_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   input  logic                     req_command,
   input  logic [IDX_W-1:0]         req_sensor_index,
   input  logic [TIME_W-1:0]        req_now_ms,
   input  logic                     req_read_ok,
   input  logic signed [TEMP_W-1:0] req_temp_tenths,
   input  logic [HUM_W-1:0]         req_hum_tenths,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_rejected,
   output logic                     rsp_due,
   output logic                     rsp_reading_valid,
   output logic                     rsp_changed_any,
   output logic                     rsp_changed_significant,
   output logic [DELAY_W-1:0]       rsp_retry_delay_ms,
   output logic [TIME_W-1:0]        rsp_next_deadline_ms
);

   // configuration
   logic [COUNT_W-1:0] count_ff;
   logic [DELAY_W-1:0] period_ff;
   logic [DELAY_W-1:0] min_ff;
   logic [DELAY_W-1:0] max_ff;
   logic [LIMIT_W-1:0] temp_limit_ff;
   logic [LIMIT_W-1:0] hum_limit_ff;

   // held request
   logic                     cmd_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [TIME_W-1:0]        now_ff;
   logic                     ok_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic [HUM_W-1:0]         hum_ff;

   // sensor table
   logic [TIME_W-1:0]        deadline_ff [SLOTS];
   logic [DELAY_W-1:0]       delay_ff [SLOTS];
   logic signed [TEMP_W-1:0] last_temp_ff [SLOTS];
   logic [HUM_W-1:0]         last_hum_ff [SLOTS];
   logic [SLOTS-1:0]         have_valid_ff;

   // response register
   logic               rsp_valid_ff;
   logic               rsp_rejected_ff;
   logic               rsp_due_ff;
   logic               rsp_reading_valid_ff;
   logic               rsp_changed_any_ff;
   logic               rsp_changed_significant_ff;
   logic [DELAY_W-1:0] rsp_delay_ff;
   logic [TIME_W-1:0]  rsp_deadline_ff;

   logic [SLOT_W-1:0]        slot;
   logic                     rejected;
   logic [TIME_W-1:0]        cur_deadline;
   logic [DELAY_W-1:0]       cur_delay;
   logic signed [TEMP_W-1:0] cur_temp;
   logic [HUM_W-1:0]         cur_hum;
   logic                     cur_valid;
   logic [TIME_W-1:0]        since_deadline;
   logic                     due;
   logic [DELAY_W-1:0]       doubled;
   logic [DELAY_W-1:0]       fail_delay;
   logic signed [TEMP_W:0]   temp_sub;
   logic [TEMP_W:0]          temp_dist;
   logic [HUM_W-1:0]         hum_dist;
   logic                     changed_any;
   logic                     changed_sig;
   logic                     is_report;
   logic                     write_slot;
   logic [DELAY_W-1:0]       delay_in;
   logic [TIME_W-1:0]        deadline_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= RST_SENSOR_COUNT;
         period_ff <= RST_POLL_PERIOD;
         min_ff <= RST_BACKOFF_MIN;
         max_ff <= RST_BACKOFF_MAX;
         temp_limit_ff <= RST_TEMP_LIMIT;
         hum_limit_ff <= RST_HUM_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SENSOR_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_POLL_PERIOD:  period_ff <= csr_wdata[DELAY_W-1:0];
            CSR_BACKOFF_MIN:  min_ff <= csr_wdata[DELAY_W-1:0];
            CSR_BACKOFF_MAX:  max_ff <= csr_wdata[DELAY_W-1:0];
            CSR_TEMP_LIMIT:   temp_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_HUM_LIMIT:    hum_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         idx_ff <= req_sensor_index;
         now_ff <= req_now_ms;
         ok_ff <= req_read_ok;
         temp_ff <= req_temp_tenths;
         hum_ff <= req_hum_tenths;
      end
   end

   always_comb begin
      slot = SLOT_W'(idx_ff);
      rejected = ({1'b0, idx_ff} >= count_ff) || (int'(idx_ff) >= SLOTS);
      cur_deadline = deadline_ff[slot];
      cur_delay = delay_ff[slot];
      cur_temp = last_temp_ff[slot];
      cur_hum = last_hum_ff[slot];
      cur_valid = have_valid_ff[slot];

      // wrap-safe: due while now is at the deadline or less than half the range past it
      since_deadline = now_ff - cur_deadline;
      due = !since_deadline[TIME_W-1];

      doubled = (cur_delay < (max_ff >> 1)) ? {cur_delay[DELAY_W-2:0], 1'b0} : max_ff;
      fail_delay = (doubled < min_ff) ? min_ff : doubled;

      temp_sub = {temp_ff[TEMP_W-1], temp_ff} - {cur_temp[TEMP_W-1], cur_temp};
      temp_dist = temp_sub[TEMP_W] ? $unsigned(-temp_sub) : $unsigned(temp_sub);
      hum_dist = (hum_ff > cur_hum) ? (hum_ff - cur_hum) : (cur_hum - hum_ff);

      changed_any = !cur_valid || (temp_dist != '0) || (hum_dist != '0);
      changed_sig = !cur_valid
         || (temp_dist >= (TEMP_W+1)'(temp_limit_ff))
         || (hum_dist >= hum_limit_ff);

      is_report = (command_type'(cmd_ff) == CMD_REPORT);
      write_slot = cmd.commit && !rejected && is_report;

      priority if (!is_report) begin
         delay_in = cur_delay;
         deadline_in = cur_deadline;
      end else if (!ok_ff) begin
         delay_in = fail_delay;
         deadline_in = now_ff + TIME_W'(fail_delay);
      end else begin
         delay_in = min_ff;
         deadline_in = now_ff + TIME_W'(period_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) begin
            deadline_ff[k] <= '0;
            delay_ff[k] <= RST_RETRY_DELAY;
            last_temp_ff[k] <= '0;
            last_hum_ff[k] <= '0;
         end
         have_valid_ff <= '0;
      end else if (write_slot) begin
         deadline_ff[slot] <= deadline_in;
         delay_ff[slot] <= delay_in;
         have_valid_ff[slot] <= ok_ff;
         if (ok_ff) begin
            last_temp_ff[slot] <= temp_ff;
            last_hum_ff[slot] <= hum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // a rejected index gives all-zero fields apart from the reject flag
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_rejected_ff <= rejected;
         rsp_due_ff <= !rejected && !is_report && due;
         rsp_reading_valid_ff <= !rejected && is_report && ok_ff;
         rsp_changed_any_ff <= !rejected && is_report && ok_ff && changed_any;
         rsp_changed_significant_ff <= !rejected && is_report && ok_ff && changed_sig;
         rsp_delay_ff <= rejected ? '0 : delay_in;
         rsp_deadline_ff <= rejected ? '0 : deadline_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rejected = rsp_rejected_ff;
   assign rsp_due = rsp_due_ff;
   assign rsp_reading_valid = rsp_reading_valid_ff;
   assign rsp_changed_any = rsp_changed_any_ff;
   assign rsp_changed_significant = rsp_changed_significant_ff;
   assign rsp_retry_delay_ms = rsp_delay_ff;
   assign rsp_next_deadline_ms = rsp_deadline_ff;

`ifndef SYNTHESIS
   a_commit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("response register overwritten before its beat was taken");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && rejected) |=> rsp_valid && rsp_rejected && !rsp_due
         && !rsp_reading_valid && rsp_retry_delay_ms == '0)
      else $error("rejected beat carries non-zero fields");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reading_valid) |-> !rsp_due && !rsp_rejected)
      else $error("good reading flagged together with due or reject");
`endif

endmodule

// ===== rtl/sensor_poll_backoff_scheduler.sv =====
// top level: request beat in, one response beat out per request
// a request is held in the input register when accepted, and its response is registered in the
// response register once the response side is free
// the two-state controller takes no new request until the last one is committed; a stalled
// response register holds the controller in its execute state until the beat is taken
// reset (synchronous, active high) restores the register defaults and clears the table
module sensor_poll_backoff_scheduler import sps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sps_req_if.sink               req_bus,
   sps_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   sps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   sps_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (dp_cmd),
      .status                  (dp_status),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .req_command             (req_bus.command),
      .req_sensor_index        (req_bus.sensor_index),
      .req_now_ms              (req_bus.now_ms),
      .req_read_ok             (req_bus.read_ok),
      .req_temp_tenths         (req_bus.temp_tenths),
      .req_hum_tenths          (req_bus.hum_tenths),
      .rsp_valid               (rsp_bus.valid),
      .rsp_ready               (rsp_bus.ready),
      .rsp_rejected            (rsp_bus.rejected),
      .rsp_due                 (rsp_bus.due),
      .rsp_reading_valid       (rsp_bus.reading_valid),
      .rsp_changed_any         (rsp_bus.changed_any),
      .rsp_changed_significant (rsp_bus.changed_significant),
      .rsp_retry_delay_ms      (rsp_bus.retry_delay_ms),
      .rsp_next_deadline_ms    (rsp_bus.next_deadline_ms)
   );

endmodule

// ===== bench/tb_sensor_poll_backoff_scheduler.sv =====
// self-checking bench for the sensor poll backoff scheduler: random and directed beats
`timescale 1ns / 1ps

module tb_sensor_poll_backoff_scheduler;
   import sps_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      command_type              cmd;
      logic [IDX_W-1:0]         idx;
      logic [TIME_W-1:0]        now;
      logic                     ok;
      logic signed [TEMP_W-1:0] temp;
      logic [HUM_W-1:0]         hum;
   } poll_request_type;

   typedef struct packed {
      logic                rejected;
      logic                due;
      logic                reading_valid;
      logic                changed_any;
      logic                changed_significant;
      logic [DELAY_W-1:0]  retry_delay;
      logic [TIME_W-1:0]   next_deadline;
   } poll_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sps_req_if req_bus ();
   sps_rsp_if rsp_bus ();

   sensor_poll_backoff_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the scheduler: settings and per-slot table
   logic [COUNT_W-1:0]       cfg_count;
   logic [DELAY_W-1:0]       cfg_period, cfg_bmin, cfg_bmax;
   logic [LIMIT_W-1:0]       cfg_tlim, cfg_hlim;
   logic [TIME_W-1:0]        slot_deadline [SLOTS];
   logic [DELAY_W-1:0]       slot_delay [SLOTS];
   logic signed [TEMP_W-1:0] slot_temp [SLOTS];
   logic [HUM_W-1:0]         slot_hum [SLOTS];
   logic                     slot_valid [SLOTS];

   poll_request_type pending_requests [$];
   poll_result_type  awaited_results [$];
   int requests_queued = 0;
   int requests_taken = 0;
   int failures = 0;
   int holds_asked = 0;
   int holds_done = 0;

   task automatic clear_schedule();
      cfg_count = RST_SENSOR_COUNT;
      cfg_period = RST_POLL_PERIOD;
      cfg_bmin = RST_BACKOFF_MIN;
      cfg_bmax = RST_BACKOFF_MAX;
      cfg_tlim = RST_TEMP_LIMIT;
      cfg_hlim = RST_HUM_LIMIT;
      for (int k = 0; k < SLOTS; k++) begin
         slot_deadline[k] = '0;
         slot_delay[k] = RST_RETRY_DELAY;
         slot_temp[k] = '0;
         slot_hum[k] = '0;
         slot_valid[k] = 1'b0;
      end
   endtask

   function automatic poll_result_type schedule_outcome(poll_request_type r);
      poll_result_type res;
      logic [31:0] nxt;
      logic [TIME_W-1:0] lag;
      int ta, tb, ha, hb, dt, dh;
      int i;
      res = '0;
      i = int'(r.idx);
      if (i >= int'(cfg_count) || i >= SLOTS) begin
         res.rejected = 1'b1;
         return res;
      end
      if (r.cmd == CMD_CHECK) begin
         lag = r.now - slot_deadline[i];
         res.due = ~lag[TIME_W-1];
      end else if (!r.ok) begin
         nxt = 32'(slot_delay[i]);
         // doubling stops at half the ceiling, then the floor wins over the ceiling
         if (nxt < 32'(cfg_bmax) / 2) nxt = nxt * 2;
         else nxt = 32'(cfg_bmax);
         if (nxt < 32'(cfg_bmin)) nxt = 32'(cfg_bmin);
         slot_delay[i] = nxt[DELAY_W-1:0];
         slot_valid[i] = 1'b0;
         slot_deadline[i] = r.now + TIME_W'(slot_delay[i]);
      end else begin
         res.changed_any = 1'b1;
         res.changed_significant = 1'b1;
         if (slot_valid[i]) begin
            ta = slot_temp[i];
            tb = r.temp;
            ha = int'(slot_hum[i]);
            hb = int'(r.hum);
            dt = (ta > tb) ? ta - tb : tb - ta;
            dh = (ha > hb) ? ha - hb : hb - ha;
            res.changed_any = (dt != 0) || (dh != 0);
            res.changed_significant = (dt >= int'(cfg_tlim)) || (dh >= int'(cfg_hlim));
         end
         slot_valid[i] = 1'b1;
         slot_temp[i] = r.temp;
         slot_hum[i] = r.hum;
         slot_delay[i] = cfg_bmin;
         slot_deadline[i] = r.now + TIME_W'(cfg_period);
         res.reading_valid = 1'b1;
      end
      res.retry_delay = slot_delay[i];
      res.next_deadline = slot_deadline[i];
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 9);
      return $urandom_range(10, 40);
   endfunction

   // sender
   int send_gap = 0;
   int send_quiet = 0;
   always @(posedge clock) begin
      poll_request_type cur;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            cur = pending_requests.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.command <= cur.cmd;
            req_bus.sensor_index <= cur.idx;
            req_bus.now_ms <= cur.now;
            req_bus.read_ok <= cur.ok;
            req_bus.temp_tenths <= cur.temp;
            req_bus.hum_tenths <= cur.hum;
            if (send_quiet > 0) begin
               send_quiet--;
            end else begin
               if ($urandom_range(0, 49) == 0) send_quiet = 60;
               send_gap = pick_gap();
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver, with long hold-offs on request
   int hold_left = 0;
   int rx_stall = 0;
   int rx_quiet = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (rx_quiet > 0) begin
         rx_quiet--;
         rsp_bus.ready <= 1'b1;
      end else if (rx_stall > 0) begin
         rx_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 49) == 0) rx_quiet = 60;
         rx_stall = pick_gap();
         rsp_bus.ready <= (rx_stall == 0);
      end
   end

   // monitor: predict on every request beat, compare every response beat
   always @(posedge clock) begin : monitor
      poll_request_type seen;
      poll_result_type want, got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.cmd = command_type'(req_bus.command);
            seen.idx = req_bus.sensor_index;
            seen.now = req_bus.now_ms;
            seen.ok = req_bus.read_ok;
            seen.temp = req_bus.temp_tenths;
            seen.hum = req_bus.hum_tenths;
            want = schedule_outcome(seen);
            awaited_results = {awaited_results, want};
            requests_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_results.size() == 0) begin
               $error("response beat with no request outstanding");
               failures++;
            end else begin
               want = awaited_results.pop_front();
               got.rejected = rsp_bus.rejected;
               got.due = rsp_bus.due;
               got.reading_valid = rsp_bus.reading_valid;
               got.changed_any = rsp_bus.changed_any;
               got.changed_significant = rsp_bus.changed_significant;
               got.retry_delay = rsp_bus.retry_delay_ms;
               got.next_deadline = rsp_bus.next_deadline_ms;
               check_field("rejected", 32'(want.rejected), 32'(got.rejected));
               check_field("due", 32'(want.due), 32'(got.due));
               check_field("reading_valid", 32'(want.reading_valid),
                           32'(got.reading_valid));
               check_field("changed_any", 32'(want.changed_any), 32'(got.changed_any));
               check_field("changed_significant", 32'(want.changed_significant),
                           32'(got.changed_significant));
               check_field("retry_delay_ms", 32'(want.retry_delay), 32'(got.retry_delay));
               check_field("next_deadline_ms", want.next_deadline, got.next_deadline);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   int stalled_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic poll_request_type request_beat(command_type cmd, int idx,
                                                     logic [TIME_W-1:0] now, logic ok,
                                                     int temp, int hum);
      poll_request_type r;
      r.cmd = cmd;
      r.idx = IDX_W'(idx);
      r.now = now;
      r.ok = ok;
      r.temp = TEMP_W'(temp);
      r.hum = HUM_W'(hum);
      return r;
   endfunction

   task automatic queue_request(poll_request_type r);
      pending_requests = {pending_requests, r};
      requests_queued++;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (requests_taken != requests_queued || awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type which, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= which;
      csr_wdata <= val;
      case (which)
         CSR_SENSOR_COUNT: cfg_count = val[COUNT_W-1:0];
         CSR_POLL_PERIOD:  cfg_period = val[DELAY_W-1:0];
         CSR_BACKOFF_MIN:  cfg_bmin = val[DELAY_W-1:0];
         CSR_BACKOFF_MAX:  cfg_bmax = val[DELAY_W-1:0];
         CSR_TEMP_LIMIT:   cfg_tlim = val[LIMIT_W-1:0];
         CSR_HUM_LIMIT:    cfg_hlim = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int count, int period, int bmin, int bmax, int tlim, int hlim);
      write_reg(CSR_SENSOR_COUNT, CSR_DATA_W'(count));
      write_reg(CSR_POLL_PERIOD, CSR_DATA_W'(period));
      write_reg(CSR_BACKOFF_MIN, CSR_DATA_W'(bmin));
      write_reg(CSR_BACKOFF_MAX, CSR_DATA_W'(bmax));
      write_reg(CSR_TEMP_LIMIT, CSR_DATA_W'(tlim));
      write_reg(CSR_HUM_LIMIT, CSR_DATA_W'(hlim));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // random traffic: a moving clock, readings that drift near the last one per slot
   logic [TIME_W-1:0] gen_now = 32'h0000_1000;
   int gen_temp [SLOTS] = '{default: 200};
   int gen_hum [SLOTS] = '{default: 500};

   task automatic queue_random(int n);
      poll_request_type r;
      int pick, idx, temp, hum;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) gen_now += $urandom_range(0, 1200);
         else if (pick < 95) gen_now += $urandom_range(0, 100000);
         else if (pick < 98) gen_now += 32'h7FFF_FFFE + $urandom_range(0, 3);
         else gen_now = $urandom();
         idx = $urandom_range(0, SLOTS - 1);
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            // noise: every field at random
            r = request_beat(command_type'($urandom_range(0, 1)), idx, $urandom(),
                             $urandom_range(0, 1), $urandom(), $urandom());
         end else if (pick < 42) begin
            r = request_beat(CMD_CHECK, idx, gen_now, $urandom_range(0, 1),
                             $urandom(), $urandom());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               temp = $urandom_range(0, 2047) - 1024;
               hum = $urandom_range(0, 1023);
            end else if (pick < 35) begin
               temp = gen_temp[idx];
               hum = gen_hum[idx];
            end else begin
               temp = gen_temp[idx] + $urandom_range(0, 12) - 6;
               hum = gen_hum[idx] + $urandom_range(0, 24) - 12;
            end
            r = request_beat(CMD_REPORT, idx, gen_now, $urandom_range(0, 3) != 0, temp, hum);
            if (r.ok) begin
               gen_temp[idx] = r.temp;
               gen_hum[idx] = int'(r.hum);
            end
         end
         queue_request(r);
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.command = CMD_CHECK;
      req_bus.sensor_index = '0;
      req_bus.now_ms = '0;
      req_bus.read_ok = 1'b0;
      req_bus.temp_tenths = '0;
      req_bus.hum_tenths = '0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_SENSOR_COUNT;
      csr_wdata = '0;
      clear_schedule();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wrap-safe due test against the reset deadline of zero
      queue_request(request_beat(CMD_CHECK, 0, 32'h0000_0000, 1'b0, 0, 0));
      queue_request(request_beat(CMD_CHECK, 1, 32'h7FFF_FFFF, 1'b1, 0, 0));
      queue_request(request_beat(CMD_CHECK, 2, 32'h8000_0000, 1'b0, 0, 0));
      queue_request(request_beat(CMD_CHECK, 3, 32'hFFFF_FFFF, 1'b1, 0, 0));
      // first reading, no change, small change, limit reached on each quantity
      queue_request(request_beat(CMD_REPORT, 0, 100, 1'b1, -400, 0));
      queue_request(request_beat(CMD_REPORT, 0, 200, 1'b1, -400, 0));
      queue_request(request_beat(CMD_REPORT, 0, 300, 1'b1, -396, 0));
      queue_request(request_beat(CMD_REPORT, 0, 400, 1'b1, -391, 0));
      queue_request(request_beat(CMD_REPORT, 0, 500, 1'b1, -391, 10));
      queue_request(request_beat(CMD_REPORT, 0, 600, 1'b1, -391, 19));
      queue_request(request_beat(CMD_CHECK, 0, 2599, 1'b0, 0, 0));
      queue_request(request_beat(CMD_CHECK, 0, 2600, 1'b0, 0, 0));
      // repeated failures walk the delay up to the ceiling
      for (int k = 0; k < 7; k++)
         queue_request(request_beat(CMD_REPORT, 1, 1000 + k, 1'b0, 55, 66));
      queue_request(request_beat(CMD_REPORT, 1, 9000, 1'b1, 800, 1000));
      // deadline wraps past the top of time
      queue_request(request_beat(CMD_REPORT, 2, 32'hFFFF_FF00, 1'b1, 1023, 1023));
      queue_request(request_beat(CMD_CHECK, 2, 32'h0000_06CF, 1'b0, 0, 0));
      queue_request(request_beat(CMD_CHECK, 2, 32'h0000_06D0, 1'b0, 0, 0));
      queue_request(request_beat(CMD_REPORT, 2, 32'h0000_0700, 1'b1, -1024, 0));
      queue_request(request_beat(CMD_REPORT, 3, 0, 1'b0, 321, 77));
      queue_random(180);
      wait_idle();

      set_config(4, 1, 1, 1000000, 0, 0);
      queue_random(180);
      wait_idle();

      // floor above ceiling
      set_config(2, 1000000, 1000000, 1, 1000, 1000);
      queue_random(180);
      wait_idle();

      // zero floor lets the delay sit at zero
      set_config(7, 'hFFFFF, 0, 'hFFFFF, 'h3FF, 1);
      queue_random(180);
      wait_idle();

      set_config(0, 2000, 1000, 60000, 5, 10);
      queue_random(30);
      wait_idle();

      set_config(3, 500, 5000, 3000, 3, 7);
      queue_random(180);
      wait_idle();

      set_config(1, $urandom_range(1, 1000000), $urandom_range(1, 5000),
                 $urandom_range(1, 1000000), $urandom_range(0, 1000), $urandom_range(0, 1000));
      queue_random(180);
      wait_idle();

      // long receiver hold-off while beats keep coming
      set_config(4, $urandom_range(1, 5000), 100, 60000, 5, 10);
      queue_random(200);
      holds_asked++;
      wait_idle();

      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sps_pkg.sv
rtl/sps_if.sv
rtl/sps_ctrl.sv
rtl/sps_dp.sv
rtl/sensor_poll_backoff_scheduler.sv
bench/tb_sensor_poll_backoff_scheduler.sv
